// File: design/cnv_pkg.sv
// ----------------------------------------------------------------------------
// Card number validator package
// This package holds the field widths, the result codes, the token passed
// from the front part to the back part, and the small digit functions.
// ----------------------------------------------------------------------------
package cnv_pkg;

    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 6;
    localparam int DIGIT_W   = 4;
    localparam int STATUS_W  = 2;
    localparam int BRAND_W   = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [LEN_W-1:0] MIN_LEN_RST = 6'd13;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = 6'd19;
    localparam logic [LEN_W-1:0] LEN_SAT     = 6'd63;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LUHN     = 2'd3;

    localparam logic [BRAND_W-1:0] BRAND_NONE = 3'd0;
    localparam logic [BRAND_W-1:0] BRAND_D4   = 3'd1;
    localparam logic [BRAND_W-1:0] BRAND_D5   = 3'd2;
    localparam logic [BRAND_W-1:0] BRAND_D6   = 3'd3;
    localparam logic [BRAND_W-1:0] BRAND_D3   = 3'd4;
    localparam logic [BRAND_W-1:0] BRAND_D3X  = 3'd5;

    typedef enum logic [1:0] {
        CK_DIGIT,
        CK_SPACE,
        CK_OTHER
    } t_char_kind;

    typedef struct packed {
        t_char_kind         kind;
        logic [DIGIT_W-1:0] digit;
        logic               is_last;
    } t_token;

    typedef struct packed {
        logic [LEN_W-1:0] min_len;
        logic [LEN_W-1:0] max_len;
    } t_len_cfg;

    function automatic t_char_kind classify(input logic [CHAR_W-1:0] c);
        t_char_kind k;
        case (c) inside
            [8'd48:8'd57]:      k = CK_DIGIT;
            [8'd9:8'd13], 8'd32: k = CK_SPACE;
            default:            k = CK_OTHER;
        endcase
        return k;
    endfunction

    function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W:0] t;
        t = {d, 1'b0};
        if (t > 5'd9) begin
            t = t - 5'd9;
        end
        return t[DIGIT_W-1:0];
    endfunction

    function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] a,
                                                      input logic [DIGIT_W-1:0] b);
        logic [DIGIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 5'd10) begin
            s = s - 5'd10;
        end
        return s[DIGIT_W-1:0];
    endfunction

    function automatic logic [BRAND_W-1:0] brand_of(input logic [DIGIT_W-1:0] lead,
                                                     input logic [DIGIT_W-1:0] second);
        logic [BRAND_W-1:0] b;
        case (lead)
            4'd3: begin
                b = (second == 4'd4 || second == 4'd7) ? BRAND_D3X : BRAND_D3;
            end
            4'd4:    b = BRAND_D4;
            4'd5:    b = BRAND_D5;
            4'd6:    b = BRAND_D6;
            default: b = BRAND_NONE;
        endcase
        return b;
    endfunction

endpackage

// File: design/cnv_in_if.sv
// ----------------------------------------------------------------------------
// Character channel
// This interface carries one text byte per beat with its final-byte flag.
// ----------------------------------------------------------------------------
interface cnv_in_if;
    import cnv_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              is_last;

    modport source(output valid, character, is_last, input ready);
    modport sink(input valid, character, is_last, output ready);
endinterface

// File: design/cnv_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// This interface carries one validation result per beat.
// ----------------------------------------------------------------------------
interface cnv_out_if;
    import cnv_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BRAND_W-1:0]  brand;
    logic [LEN_W-1:0]    digit_total;

    modport source(output valid, status, brand, digit_total, input ready);
    modport sink(input valid, status, brand, digit_total, output ready);
endinterface

// File: design/cnv_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// This interface carries one register write per beat.
// ----------------------------------------------------------------------------
interface cnv_cfg_if;
    import cnv_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [LEN_W-1:0]     data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: design/card_number_validator.sv
// ----------------------------------------------------------------------------
// Card number validator
// Checks a card number string with the Luhn mod-10 rule and reports status,
// brand and digit count.
// ----------------------------------------------------------------------------
// The block takes one character beat per clock cycle, back to back, while the
// token queue is not full, and gives one result beat for each beat flagged as
// the final character. A character is classified on entry, passes through a
// small token queue, and is folded into the running sums by the back end.
// The final character is written into the queue, popped by the back end and
// loaded into the registered result, unless an earlier result is still
// waiting on the output; while a result waits, characters of the next string
// keep flowing until the queue fills. The length limits are written through
// the configuration channel, index 0 for the minimum and 1 for the maximum;
// the user writes them only while the block is idle, which it does not enforce.
module card_number_validator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cnv_in_if.sink    i_in,
    cnv_cfg_if.sink   i_cfg,
    cnv_out_if.source o_res
);
    import cnv_pkg::*;

    t_len_cfg r_len_cfg;
    t_token   front_tok;
    t_token   q_tok;
    logic     push;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg.min_len <= MIN_LEN_RST;
            r_len_cfg.max_len <= MAX_LEN_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_MIN_LEN: r_len_cfg.min_len <= i_cfg.data;
                CFG_MAX_LEN: r_len_cfg.max_len <= i_cfg.data;
                default:     ;
            endcase
        end
    end

    cnv_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_tok    (front_tok)
    );

    cnv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (front_tok),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_tok   (q_tok)
    );

    cnv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_len_cfg),
        .i_q_valid (q_valid),
        .i_q_tok   (q_tok),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

// File: design/cnv_front.sv
// ----------------------------------------------------------------------------
// Card number validator front end
// This module accepts text bytes, classifies each one as digit, whitespace or
// other, and pushes a token into the queue. Whitespace that does not end the
// string has no effect and is dropped here.
// ----------------------------------------------------------------------------
module cnv_front (
    cnv_in_if.sink   i_in,
    input  logic     i_q_full,
    output logic     o_push,
    output cnv_pkg::t_token o_tok
);
    import cnv_pkg::*;

    t_char_kind kind;

    assign kind       = classify(i_in.character);
    assign i_in.ready = !i_q_full;

    assign o_tok.kind    = kind;
    assign o_tok.digit   = i_in.character[DIGIT_W-1:0];
    assign o_tok.is_last = i_in.is_last;

    assign o_push = i_in.valid && i_in.ready && !(kind == CK_SPACE && !i_in.is_last);

endmodule

// File: design/cnv_queue.sv
// ----------------------------------------------------------------------------
// Card number validator token queue
// A small FIFO between the front end and the back end, so that each side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module cnv_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cnv_pkg::t_token i_tok,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output cnv_pkg::t_token o_tok
);
    import cnv_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_token        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("token pushed into a full queue");
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("token popped from an empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond its depth");
`endif

endmodule

// File: design/cnv_back.sv
// ----------------------------------------------------------------------------
// Card number validator back end
// This module keeps the running Luhn sums, digit count and leading digits of
// the current string, and on the final token loads the result register.
// ----------------------------------------------------------------------------
module cnv_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cnv_pkg::t_len_cfg i_cfg,
    input  logic              i_q_valid,
    input  cnv_pkg::t_token   i_q_tok,
    output logic              o_q_pop,
    cnv_out_if.source         o_res
);
    import cnv_pkg::*;

    logic               r_bad;
    logic               r_ovf;
    logic [LEN_W-1:0]   r_cnt;
    logic [DIGIT_W-1:0] r_sum_even;
    logic [DIGIT_W-1:0] r_sum_odd;
    logic [DIGIT_W-1:0] r_lead;
    logic [DIGIT_W-1:0] r_second;
    logic               r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [BRAND_W-1:0]  r_brand;
    logic [LEN_W-1:0]    r_total;

    logic               u_bad;
    logic               u_ovf;
    logic [LEN_W-1:0]   u_cnt;
    logic [DIGIT_W-1:0] u_sum_even;
    logic [DIGIT_W-1:0] u_sum_odd;
    logic [DIGIT_W-1:0] u_lead;
    logic [DIGIT_W-1:0] u_second;
    logic [DIGIT_W-1:0] dbl;
    logic [DIGIT_W-1:0] pick_sum;
    logic [STATUS_W-1:0] res_status;
    logic [BRAND_W-1:0]  res_brand;
    logic               finish;

    assign o_q_pop = i_q_valid && (!i_q_tok.is_last || !r_out_valid || o_res.ready);
    assign finish  = o_q_pop && i_q_tok.is_last;
    assign dbl     = luhn_double(i_q_tok.digit);

    always_comb begin
        u_bad      = r_bad;
        u_ovf      = r_ovf;
        u_cnt      = r_cnt;
        u_sum_even = r_sum_even;
        u_sum_odd  = r_sum_odd;
        u_lead     = r_lead;
        u_second   = r_second;
        case (i_q_tok.kind)
            CK_DIGIT: begin
                if (!r_ovf && r_cnt == 6'd0) begin
                    u_lead = i_q_tok.digit;
                end
                if (!r_ovf && r_cnt == 6'd1) begin
                    u_second = i_q_tok.digit;
                end
                if (!r_cnt[0]) begin
                    u_sum_even = add_mod10(r_sum_even, dbl);
                    u_sum_odd  = add_mod10(r_sum_odd, i_q_tok.digit);
                end else begin
                    u_sum_even = add_mod10(r_sum_even, i_q_tok.digit);
                    u_sum_odd  = add_mod10(r_sum_odd, dbl);
                end
                if (r_cnt == LEN_SAT) begin
                    u_ovf = 1'b1;
                end else begin
                    u_cnt = r_cnt + 1'b1;
                end
            end
            CK_OTHER: u_bad = 1'b1;
            default:  ;
        endcase
    end

    always_comb begin
        pick_sum = u_cnt[0] ? u_sum_odd : u_sum_even;
        if (u_bad) begin
            res_status = ST_BAD_CHAR;
        end else if (u_ovf || u_cnt < i_cfg.min_len || u_cnt > i_cfg.max_len) begin
            res_status = ST_BAD_LEN;
        end else if (pick_sum != '0) begin
            res_status = ST_LUHN;
        end else begin
            res_status = ST_OK;
        end
        res_brand = (u_cnt < 6'd2) ? BRAND_NONE : brand_of(u_lead, u_second);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad       <= 1'b0;
            r_ovf       <= 1'b0;
            r_cnt       <= '0;
            r_sum_even  <= '0;
            r_sum_odd   <= '0;
            r_lead      <= '0;
            r_second    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (finish) begin
                r_bad      <= 1'b0;
                r_ovf      <= 1'b0;
                r_cnt      <= '0;
                r_sum_even <= '0;
                r_sum_odd  <= '0;
                r_lead     <= '0;
                r_second   <= '0;
            end else if (o_q_pop) begin
                r_bad      <= u_bad;
                r_ovf      <= u_ovf;
                r_cnt      <= u_cnt;
                r_sum_even <= u_sum_even;
                r_sum_odd  <= u_sum_odd;
                r_lead     <= u_lead;
                r_second   <= u_second;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_status <= res_status;
            r_brand  <= res_brand;
            r_total  <= u_cnt;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_status;
    assign o_res.brand       = r_brand;
    assign o_res.digit_total = r_total;

`ifndef SYNTHESIS
    a_ovf_at_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_cnt == LEN_SAT)
        else $error("count overflow flag set below saturation");
    a_sums_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_even <= 4'd9 && r_sum_odd <= 4'd9)
        else $error("Luhn running sum outside 0 to 9");
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_cnt == '0 && !r_ovf && !r_bad)
        else $error("string state not cleared after the final beat");
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_out_valid)
        else $error("final beat did not load a result");
`endif

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Card number validator testbench
// Streams card number text into the validator and checks each result beat
// against an in-bench predictor that rebuilds status, brand and digit count. It starts
// with a short directed set, then runs random phases under several length
// limits, with idle bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import cnv_pkg::*;

    localparam int STALL_LIMIT     = 1000;
    localparam int CHARS_PER_PHASE = 175;
    localparam int PHASES          = 6;

    typedef enum {STR_GOOD, STR_TYPO, STR_JUNK, STR_NOISE} t_str_kind;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              is_last;
    } t_char_beat;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BRAND_W-1:0]  brand;
        logic [LEN_W-1:0]    digit_total;
    } t_card_result;

    typedef struct packed {
        logic               bad_char;
        logic               overflow;
        logic [LEN_W-1:0]   count;
        logic [DIGIT_W-1:0] sum_even;
        logic [DIGIT_W-1:0] sum_odd;
        logic [DIGIT_W-1:0] lead;
        logic [DIGIT_W-1:0] second;
    } t_card_acc;

    logic i_clk;
    logic i_rst_n;

    cnv_in_if  char_if ();
    cnv_cfg_if cfg_if ();
    cnv_out_if res_if ();

    t_char_beat       pending_chars[$];
    t_card_result     expected_results[$];
    t_card_acc        acc;
    logic [LEN_W-1:0] len_min;
    logic [LEN_W-1:0] len_max;
    logic [CHAR_W-1:0] ws_bytes [6];
    bit               quiet;
    int               idle_pct;
    int               send_gap;
    int               hold_gap;
    int               errors;
    int               stuck_cycles;

    card_number_validator dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (char_if),
        .i_cfg  (cfg_if),
        .o_res  (res_if)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_char_kind char_kind(input logic [CHAR_W-1:0] c);
        if (c >= 8'd48 && c <= 8'd57) begin
            return CK_DIGIT;
        end
        if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32) begin
            return CK_SPACE;
        end
        return CK_OTHER;
    endfunction

    task automatic fold_char(input logic [CHAR_W-1:0] c, input logic last_flag);
        int                 d;
        int                 dbl;
        logic [DIGIT_W-1:0] pick;
        t_card_result       r;
        case (char_kind(c))
            CK_DIGIT: begin
                d   = c - 48;
                dbl = (2 * d > 9) ? 2 * d - 9 : 2 * d;
                if (!acc.overflow && acc.count == 0) begin
                    acc.lead = d[DIGIT_W-1:0];
                end else if (!acc.overflow && acc.count == 1) begin
                    acc.second = d[DIGIT_W-1:0];
                end
                if (!acc.count[0]) begin
                    acc.sum_even = DIGIT_W'((acc.sum_even + dbl) % 10);
                    acc.sum_odd  = DIGIT_W'((acc.sum_odd + d) % 10);
                end else begin
                    acc.sum_even = DIGIT_W'((acc.sum_even + d) % 10);
                    acc.sum_odd  = DIGIT_W'((acc.sum_odd + dbl) % 10);
                end
                if (acc.count == LEN_SAT) begin
                    acc.overflow = 1'b1;
                end else begin
                    acc.count = acc.count + 1'b1;
                end
            end
            CK_OTHER: acc.bad_char = 1'b1;
            default: ;
        endcase
        if (last_flag) begin
            pick = acc.count[0] ? acc.sum_odd : acc.sum_even;
            if (acc.bad_char) begin
                r.status = ST_BAD_CHAR;
            end else if (acc.overflow || acc.count < len_min || acc.count > len_max) begin
                r.status = ST_BAD_LEN;
            end else if (pick != 0) begin
                r.status = ST_LUHN;
            end else begin
                r.status = ST_OK;
            end
            if (acc.count < 2 && !acc.overflow) begin
                r.brand = BRAND_NONE;
            end else begin
                case (acc.lead)
                    4'd3: begin
                        r.brand = (acc.second == 4'd4 || acc.second == 4'd7) ?
                                  BRAND_D3X : BRAND_D3;
                    end
                    4'd4:    r.brand = BRAND_D4;
                    4'd5:    r.brand = BRAND_D5;
                    4'd6:    r.brand = BRAND_D6;
                    default: r.brand = BRAND_NONE;
                endcase
            end
            r.digit_total = acc.count;
            expected_results.push_back(r);
            acc = '0;
        end
    endtask

    task automatic push_char(input logic [CHAR_W-1:0] c, input logic last_flag);
        pending_chars.push_back('{c, last_flag});
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic queue_random_strings(input int budget);
        int                made;
        int                n;
        int                r;
        int                lo;
        int                hi;
        int                pos;
        int                s;
        int                d;
        int                digs[$];
        logic [CHAR_W-1:0] text[$];
        logic [CHAR_W-1:0] c;
        t_str_kind         kind;
        made = 0;
        while (made < budget) begin
            digs.delete();
            text.delete();
            r = $urandom_range(0, 99);
            if (r < 55) begin
                kind = STR_GOOD;
            end else if (r < 75) begin
                kind = STR_TYPO;
            end else if (r < 90) begin
                kind = STR_JUNK;
            end else begin
                kind = STR_NOISE;
            end
            lo = int'((len_min < len_max) ? len_min : len_max);
            lo = (lo > 1) ? lo - 1 : 1;
            hi = int'((len_min > len_max) ? len_min : len_max) + 1;
            r = $urandom_range(0, 19);
            if (r < 2) begin
                n = $urandom_range(60, 70);
            end else if (r < 10) begin
                n = $urandom_range(1, 20);
            end else begin
                n = $urandom_range(lo, hi);
            end
            if (kind == STR_NOISE) begin
                repeat (n) text.push_back(CHAR_W'($urandom_range(0, 255)));
            end else begin
                for (int i = 0; i < n - 1; i++) begin
                    digs.push_back($urandom_range(0, 9));
                end
                if (n >= 3 && digs[0] == 3 && $urandom_range(0, 1) == 1) begin
                    digs[1] = ($urandom_range(0, 1) == 1) ? 4 : 7;
                end
                // The check digit goes on the right end, so its left neighbor is doubled.
                s = 0;
                for (int i = 0; i < n - 1; i++) begin
                    d = digs[n - 2 - i];
                    s += (i % 2 == 1) ? d : ((2 * d > 9) ? 2 * d - 9 : 2 * d);
                end
                digs.push_back((10 - s % 10) % 10);
                if (kind == STR_TYPO) begin
                    pos = $urandom_range(0, n - 1);
                    digs[pos] = (digs[pos] + $urandom_range(1, 9)) % 10;
                end
                foreach (digs[i]) begin
                    if ($urandom_range(0, 9) == 0) begin
                        text.push_back(ws_bytes[$urandom_range(0, 5)]);
                    end
                    text.push_back(CHAR_W'(48 + digs[i]));
                end
                if ($urandom_range(0, 7) == 0) begin
                    text.push_back(ws_bytes[$urandom_range(0, 5)]);
                end
                if (kind == STR_JUNK) begin
                    do begin
                        c = CHAR_W'($urandom_range(0, 255));
                    end while (char_kind(c) != CK_OTHER);
                    pos = $urandom_range(0, text.size());
                    if (pos == text.size()) begin
                        text.push_back(c);
                    end else begin
                        text.insert(pos, c);
                    end
                end
            end
            foreach (text[i]) begin
                push_char(text[i], i == text.size() - 1);
            end
            made += text.size();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        if (idx == CFG_MIN_LEN) begin
            len_min = value;
        end else begin
            len_max = value;
        end
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0 || char_if.valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : char_driver
        t_char_beat nxt;
        if (!i_rst_n) begin
            char_if.valid <= 1'b0;
            send_gap      <= 0;
        end else begin
            if (char_if.valid && char_if.ready) begin
                fold_char(char_if.character, char_if.is_last);
            end
            if (!(char_if.valid && !char_if.ready)) begin
                if (send_gap != 0) begin
                    char_if.valid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                    char_if.valid <= 1'b0;
                    send_gap      <= $urandom_range(0, 6);
                end else if (pending_chars.size() != 0) begin
                    nxt               = pending_chars.pop_front();
                    char_if.valid     <= 1'b1;
                    char_if.character <= nxt.character;
                    char_if.is_last   <= nxt.is_last;
                end else begin
                    char_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_gap     <= 0;
        end else if (hold_gap != 0) begin
            res_if.ready <= 1'b0;
            hold_gap     <= hold_gap - 1;
        end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            res_if.ready <= 1'b0;
            hold_gap     <= $urandom_range(0, 6);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_card_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected result beat: status %0d brand %0d digits %0d",
                             res_if.status, res_if.brand, res_if.digit_total);
                end
            end else begin
                want = expected_results.pop_front();
                if (want.status !== res_if.status || want.brand !== res_if.brand ||
                    want.digit_total !== res_if.digit_total) begin
                    errors++;
                    if (errors <= 10) begin
                        $display({"Result mismatch: expected status %0d brand %0d ",
                                  "digits %0d, got status %0d brand %0d digits %0d"},
                                 want.status, want.brand, want.digit_total,
                                 res_if.status, res_if.brand, res_if.digit_total);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (char_if.valid && char_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int phase_min [PHASES];
        int phase_max [PHASES];
        int phase_idle [PHASES];
        phase_min  = '{13, 1, 63, 20, 1, 12};
        phase_max  = '{19, 63, 63, 10, 1, 16};
        phase_idle = '{20, 0, 30, 15, 40, 0};
        ws_bytes   = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};

        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        char_if.valid     = 1'b0;
        char_if.character = '0;
        char_if.is_last   = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_MIN_LEN;
        cfg_if.data       = '0;
        res_if.ready      = 1'b0;
        quiet             = 1'b0;
        idle_pct          = 0;
        errors            = 0;
        acc               = '0;
        len_min           = MIN_LEN_RST;
        len_max           = MAX_LEN_RST;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short limits so that tiny strings reach every status and every brand but D4.
        idle_pct = 25;
        write_reg(CFG_MIN_LEN, 6'd1);
        write_reg(CFG_MAX_LEN, 6'd4);
        cfg_if.valid <= 1'b0;
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b1);
        push_char(8'd32, 1'b1);
        queue_text("34");
        queue_text("37");
        queue_text("35");
        queue_text("4");
        queue_text("59");
        push_char("6", 1'b0);
        push_char(8'd13, 1'b0);
        push_char("0", 1'b1);
        queue_text("18");
        queue_text("0");
        queue_text("12345");
        push_char("9", 1'b0);
        push_char(8'd9, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_reg(CFG_MIN_LEN, LEN_W'(phase_min[p]));
            write_reg(CFG_MAX_LEN, LEN_W'(phase_max[p]));
            cfg_if.valid <= 1'b0;
            idle_pct = phase_idle[p];
            quiet    = (p == PHASES - 1);
            queue_random_strings(CHARS_PER_PHASE);
        end
        wait_drained();

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
